>>> sv/can_mbx_pkg.sv
// Shared types, register offsets and codes of the CAN mailbox register controller.
package can_mbx_pkg;

  localparam int NODES_DEF       = 2;
  localparam int FRAME_BYTES_DEF = 10;

  localparam int ADDR_W = 14;
  localparam int DATA_W = 8;

  // operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // register byte offsets
  localparam logic [ADDR_W-1:0] REG_CONTROL = 14'd0;
  localparam logic [ADDR_W-1:0] REG_COMMAND = 14'd1;
  localparam logic [ADDR_W-1:0] REG_STATUS  = 14'd2;
  localparam logic [ADDR_W-1:0] REG_INT     = 14'd3;
  localparam logic [ADDR_W-1:0] REG_ACODE   = 14'd4;
  localparam logic [ADDR_W-1:0] REG_AMASK   = 14'd5;
  localparam logic [ADDR_W-1:0] REG_BTR0    = 14'd6;
  localparam logic [ADDR_W-1:0] REG_BTR1    = 14'd7;

  localparam logic [DATA_W-1:0] MBOX_EMPTY      = 8'hff;
  localparam logic [DATA_W-1:0] NODE_RESET_CODE = 8'h01;
  localparam logic [DATA_W-1:0] READ_CONTROL    = 8'h01;
  localparam logic [DATA_W-1:0] READ_COMMAND    = 8'hff;
  localparam logic [DATA_W-1:0] READ_STATUS     = 8'h00;
  localparam logic [DATA_W-1:0] READ_UNMAPPED   = 8'hff;

  typedef struct packed {
    logic [1:0]        op;
    logic              node;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              irq_level;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic tx_step;
    logic rx_step;
    logic out_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_send;
    logic is_tick_copy;
    logic cnt_done;
    logic out_free;
  } ctl_sts_t;

endpackage

>>> sv/can_mbx_ctrl.sv
// Sequencing state machine of the CAN mailbox register controller.
module can_mbx_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  can_mbx_pkg::ctl_sts_t sts_i,
  output can_mbx_pkg::ctl_cmd_t cmd_o
);
  import can_mbx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TX_COPY,
    S_RX_COPY,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_send) begin
          state_d = S_TX_COPY;
        end else if (sts_i.is_tick_copy) begin
          state_d = S_RX_COPY;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_TX_COPY: begin
        cmd_o.tx_step = 1'b1;
        if (sts_i.cnt_done) begin
          state_d = S_FINISH;
        end
      end
      S_RX_COPY: begin
        cmd_o.rx_step = 1'b1;
        if (sts_i.cnt_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> state_q == S_EXEC)
    else $error("accepted transfer did not enter execute");
  a_send_copies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && sts_i.is_send) |=> state_q == S_TX_COPY)
    else $error("send did not start the frame copy");
  a_copy_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TX_COPY && sts_i.cnt_done) |=> state_q == S_FINISH)
    else $error("frame copy did not finish");
`endif

endmodule

>>> sv/can_mbx_datapath.sv
// Register file, frame buffers, mailbox and result register of the CAN mailbox controller.
module can_mbx_datapath #(
  parameter int NODES       = can_mbx_pkg::NODES_DEF,
  parameter int FRAME_BYTES = can_mbx_pkg::FRAME_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  can_mbx_pkg::in_item_t  in_item_i,
  input  can_mbx_pkg::ctl_cmd_t  cmd_i,
  output can_mbx_pkg::ctl_sts_t  sts_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output can_mbx_pkg::out_item_t out_item_o
);
  import can_mbx_pkg::*;

  localparam int NW      = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int ENTRIES = NODES * FRAME_BYTES;
  localparam int EW      = $clog2(ENTRIES);
  localparam int FW      = $clog2(FRAME_BYTES);
  localparam int CW      = $clog2(FRAME_BYTES + 1);

  in_item_t item_q;

  // per-node registers
  logic [1:0]        flags_q [NODES];
  logic              irq_q   [NODES];
  logic [DATA_W-1:0] acode_q [NODES];
  logic [DATA_W-1:0] amask_q [NODES];
  logic [DATA_W-1:0] btr0_q  [NODES];
  logic [DATA_W-1:0] btr1_q  [NODES];
  logic [DATA_W-1:0] sender_q;

  // buffers: entries not valid read as zero
  logic [DATA_W-1:0] tx_mem [ENTRIES];
  logic [DATA_W-1:0] rx_mem [ENTRIES];
  logic [DATA_W-1:0] mb_mem [FRAME_BYTES];
  logic              tx_vld_q [ENTRIES];
  logic              rx_vld_q [ENTRIES];
  logic [DATA_W-1:0] tx_rd_q, rx_rd_q, mb_rd_q;
  logic              tx_rd_vld_q, rx_rd_vld_q;

  logic [CW-1:0] cnt_q;
  logic [FW-1:0] cnt_idx, cnt_prev;
  logic          cnt_lt, cnt_nz;

  logic          out_valid_q;
  out_item_t     out_item_q;

  logic [NW-1:0] node_idx;
  logic          node_ok;
  logic          is_read, is_write, is_tick;
  logic          is_send, is_node_rst, is_tick_copy;
  logic          in_tx, in_rx;
  logic [FW-1:0] tx_off, rx_off;
  logic [EW-1:0] bus_tx_ent, bus_rx_ent, copy_ent, copy_prev_ent;

  logic              tx_re, tx_we, rx_re, rx_we, mb_re, mb_we;
  logic [EW-1:0]     tx_ra, rx_wa;
  logic [DATA_W-1:0] rx_wd, mb_wd, rd_byte;

  // ---- decode of the held item
  assign node_idx = NW'(item_q.node);
  assign node_ok  = (32'(item_q.node) < NODES);
  assign is_read  = node_ok && (item_q.op == OP_READ);
  assign is_write = node_ok && (item_q.op == OP_WRITE);
  assign is_tick  = node_ok && (item_q.op == OP_TICK);

  assign is_send     = is_write && (item_q.addr == REG_COMMAND) && item_q.wdata[0];
  assign is_node_rst = is_write && (item_q.addr == REG_CONTROL) &&
                       (item_q.wdata == NODE_RESET_CODE);
  assign is_tick_copy = is_tick && (sender_q != MBOX_EMPTY) &&
                        (sender_q != DATA_W'(node_idx));

  assign in_tx = (item_q.addr >= ADDR_W'(FRAME_BYTES)) &&
                 (item_q.addr <  ADDR_W'(2 * FRAME_BYTES));
  assign in_rx = (item_q.addr >= ADDR_W'(2 * FRAME_BYTES)) &&
                 (item_q.addr <  ADDR_W'(3 * FRAME_BYTES));
  assign tx_off = FW'(item_q.addr - ADDR_W'(FRAME_BYTES));
  assign rx_off = FW'(item_q.addr - ADDR_W'(2 * FRAME_BYTES));

  assign cnt_idx  = cnt_q[FW-1:0];
  assign cnt_prev = FW'(cnt_q - CW'(1));
  assign cnt_lt   = (cnt_q < CW'(FRAME_BYTES));
  assign cnt_nz   = (cnt_q != '0);

  assign bus_tx_ent    = EW'(node_idx * FRAME_BYTES + tx_off);
  assign bus_rx_ent    = EW'(node_idx * FRAME_BYTES + rx_off);
  assign copy_ent      = EW'(node_idx * FRAME_BYTES + cnt_idx);
  assign copy_prev_ent = EW'(node_idx * FRAME_BYTES + cnt_prev);

  // ---- memory ports
  assign tx_re = (cmd_i.exec && is_read && in_tx) || (cmd_i.tx_step && cnt_lt);
  assign tx_ra = cmd_i.exec ? bus_tx_ent : copy_ent;
  assign tx_we = cmd_i.exec && is_write && in_tx;

  assign rx_re = cmd_i.exec && is_read && in_rx;
  assign rx_we = (cmd_i.exec && is_write && in_rx) || (cmd_i.rx_step && cnt_nz);
  assign rx_wa = cmd_i.exec ? bus_rx_ent : copy_prev_ent;
  assign rx_wd = cmd_i.exec ? item_q.wdata : mb_rd_q;

  assign mb_we = cmd_i.tx_step && cnt_nz;
  assign mb_wd = tx_rd_vld_q ? tx_rd_q : '0;
  assign mb_re = cmd_i.rx_step && cnt_lt;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[bus_tx_ent] <= item_q.wdata;
    end
    if (tx_re) begin
      tx_rd_q     <= tx_mem[tx_ra];
      tx_rd_vld_q <= tx_vld_q[tx_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_wa] <= rx_wd;
    end
    if (rx_re) begin
      rx_rd_q     <= rx_mem[bus_rx_ent];
      rx_rd_vld_q <= rx_vld_q[bus_rx_ent];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mb_we) begin
      mb_mem[cnt_prev] <= mb_wd;
    end
    if (mb_re) begin
      mb_rd_q <= mb_mem[cnt_idx];
    end
  end

  // valid bits: node reset clears a node's entries at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tx_vld_q[i] <= 1'b0;
        rx_vld_q[i] <= 1'b0;
      end
    end else begin
      for (int n = 0; n < NODES; n++) begin
        for (int j = 0; j < FRAME_BYTES; j++) begin
          if (cmd_i.exec && is_node_rst && (NW'(n) == node_idx)) begin
            tx_vld_q[n * FRAME_BYTES + j] <= 1'b0;
            rx_vld_q[n * FRAME_BYTES + j] <= 1'b0;
          end
        end
      end
      if (tx_we) begin
        tx_vld_q[bus_tx_ent] <= 1'b1;
      end
      if (rx_we) begin
        rx_vld_q[rx_wa] <= 1'b1;
      end
    end
  end

  // copy counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.exec) begin
      cnt_q <= '0;
    end else if ((cmd_i.tx_step || cmd_i.rx_step) && cnt_lt) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // per-node registers and mailbox sender
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NODES; n++) begin
        flags_q[n] <= '0;
        irq_q[n]   <= 1'b0;
        acode_q[n] <= '0;
        amask_q[n] <= '0;
        btr0_q[n]  <= '0;
        btr1_q[n]  <= '0;
      end
      sender_q <= MBOX_EMPTY;
    end else if (cmd_i.exec) begin
      if (is_node_rst) begin
        flags_q[node_idx] <= '0;
        acode_q[node_idx] <= '0;
        amask_q[node_idx] <= '0;
        btr0_q[node_idx]  <= '0;
        btr1_q[node_idx]  <= '0;
      end
      if (is_send) begin
        sender_q             <= DATA_W'(node_idx);
        flags_q[node_idx][1] <= 1'b1;
        irq_q[node_idx]      <= 1'b1;
      end
      if (is_write) begin
        case (item_q.addr)
          REG_INT: begin
            // bit 0 wins over bit 1
            if (item_q.wdata[0]) begin
              flags_q[node_idx][0] <= 1'b0;
              irq_q[node_idx]      <= 1'b0;
            end else if (item_q.wdata[1]) begin
              flags_q[node_idx][1] <= 1'b0;
              irq_q[node_idx]      <= 1'b0;
            end
          end
          REG_ACODE: acode_q[node_idx] <= item_q.wdata;
          REG_AMASK: amask_q[node_idx] <= item_q.wdata;
          REG_BTR0:  btr0_q[node_idx]  <= item_q.wdata;
          REG_BTR1:  btr1_q[node_idx]  <= item_q.wdata;
          default: begin
          end
        endcase
      end
      if (is_tick_copy) begin
        flags_q[node_idx][0] <= 1'b1;
        irq_q[node_idx]      <= 1'b1;
        sender_q             <= MBOX_EMPTY;
      end
    end
  end

  // ---- read mux
  always_comb begin
    rd_byte = '0;
    if (is_read) begin
      case (item_q.addr)
        REG_CONTROL: rd_byte = READ_CONTROL;
        REG_COMMAND: rd_byte = READ_COMMAND;
        REG_STATUS:  rd_byte = READ_STATUS;
        REG_INT:     rd_byte = DATA_W'(flags_q[node_idx]);
        REG_ACODE:   rd_byte = acode_q[node_idx];
        REG_AMASK:   rd_byte = amask_q[node_idx];
        REG_BTR0:    rd_byte = btr0_q[node_idx];
        REG_BTR1:    rd_byte = btr1_q[node_idx];
        default: begin
          if (in_tx) begin
            rd_byte = tx_rd_vld_q ? tx_rd_q : '0;
          end else if (in_rx) begin
            rd_byte = rx_rd_vld_q ? rx_rd_q : '0;
          end else begin
            rd_byte = READ_UNMAPPED;
          end
        end
      endcase
    end
  end

  // ---- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_q.rdata     <= rd_byte;
      out_item_q.irq_level <= node_ok ? irq_q[node_idx] : 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign sts_o.is_send      = is_send;
  assign sts_o.is_tick_copy = is_tick_copy;
  assign sts_o.cnt_done     = (cnt_q == CW'(FRAME_BYTES));
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  a_send_fills_mbox: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_send) |=> sender_q != MBOX_EMPTY)
    else $error("send left the mailbox empty");
  a_tick_empties_mbox: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && is_tick_copy) |=> sender_q == MBOX_EMPTY)
    else $error("receive did not empty the mailbox");
  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> out_valid_q)
    else $error("result not posted");
`endif

endmodule

>>> sv/can_mailbox_register_controller_unit.sv
// Top level of the CAN mailbox register controller: controller plus datapath.
//
// Register interface of NODES controller nodes that share one frame mailbox of
// FRAME_BYTES bytes. Each input transfer is a byte read, a byte write or a receive tick
// addressed to one node, and yields exactly one result transfer carrying the
// read byte (zero unless a read) and the node's interrupt line after the step.
// Steps: a register access or a tick with nothing to copy goes from acceptance
// to result through accept, execute and post result. A send (command bit 0)
// or a receive tick that takes a frame adds a copy step after execute: the
// frame bytes move one per cycle through the single read port of the transmit
// buffer or the mailbox, and the last registered read is drained before the
// step ends. Input is accepted whenever the sequencer is idle, even while the
// previous result still waits in the output register; a new result waits only
// while that register is full and not being taken. Buffer clears on a node reset
// happen at once through per-entry valid bits; there is no clearing pass after reset.
module can_mailbox_register_controller_unit #(
  parameter int NODES       = can_mbx_pkg::NODES_DEF,
  parameter int FRAME_BYTES = can_mbx_pkg::FRAME_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  can_mbx_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output can_mbx_pkg::out_item_t out_item_o
);
  import can_mbx_pkg::*;

  // command and status between sequencer and datapath
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  can_mbx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  can_mbx_datapath #(
    .NODES       (NODES),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
